// ===== rtl/haptic_rhythm_sequencer_assert.svh =====
// Assertion macros for the haptic rhythm sequencer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef HAPTIC_RHYTHM_SEQUENCER_ASSERT_SVH
`define HAPTIC_RHYTHM_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define HRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hrs_pkg.sv =====
// Package for the haptic rhythm sequencer: beat ROM, rhythm tables, constants.
// No dependencies.
package hrs_pkg;

  localparam int NUM_BEATS   = 84;
  localparam int NUM_SLOTS   = 15;

  localparam logic [7:0]  PCT_UNITY   = 8'd100;
  localparam logic [7:0]  DUR_MAX     = 8'd255;
  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam logic [15:0] RECIP_100   = 16'd5243;
  localparam int          RECIP_SHIFT = 19;

  // bit 8 set: pulse, low byte is percent; clear: silence, low byte is ms
  localparam logic [8:0] BEAT_ROM [NUM_BEATS] = '{
    9'd456, 9'd255, 9'd255,
    9'd356, 9'd90,  9'd356,
    9'd356, 9'd90,  9'd356, 9'd90,  9'd356,
    9'd436, 9'd80,  9'd336,
    9'd336, 9'd80,  9'd436,
    9'd336, 9'd70,  9'd336, 9'd70,  9'd436,
    9'd436, 9'd70,  9'd336, 9'd70,  9'd336,
    9'd356, 9'd100, 9'd356, 9'd100, 9'd356, 9'd100, 9'd356,
    9'd356, 9'd160, 9'd356, 9'd120, 9'd356, 9'd90,  9'd356, 9'd70,  9'd356,
    9'd356, 9'd70,  9'd356, 9'd90,  9'd356, 9'd120, 9'd356, 9'd160, 9'd356,
    9'd356, 9'd70,  9'd356, 9'd70,  9'd356, 9'd255, 9'd45,  9'd396,
    9'd376, 9'd70,  9'd376, 9'd255, 9'd195,
    9'd456, 9'd120, 9'd326, 9'd70,  9'd326,
    9'd336, 9'd60,  9'd336, 9'd60,  9'd336, 9'd60,  9'd336, 9'd60,  9'd336,
    9'd356, 9'd200, 9'd356, 9'd70,  9'd356
  };

  localparam logic [6:0] RHYTHM_START [NUM_SLOTS] = '{
    7'd0, 7'd3, 7'd6, 7'd11, 7'd14, 7'd17, 7'd22, 7'd27,
    7'd34, 7'd43, 7'd52, 7'd60, 7'd65, 7'd70, 7'd79
  };

  localparam logic [3:0] RHYTHM_LEN [NUM_SLOTS] = '{
    4'd3, 4'd3, 4'd5, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7,
    4'd9, 4'd9, 4'd8, 4'd5, 4'd5, 4'd9, 4'd5
  };

  function automatic logic [8:0] beat_word(input logic [6:0] addr);
    return (addr < 7'(NUM_BEATS)) ? BEAT_ROM[addr] : BEAT_ROM[0];
  endfunction

  function automatic logic [6:0] rhythm_start(input logic [3:0] idx);
    return (idx < 4'(NUM_SLOTS)) ? RHYTHM_START[idx] : 7'd0;
  endfunction

  function automatic logic [3:0] rhythm_len(input logic [3:0] idx);
    return (idx < 4'(NUM_SLOTS)) ? RHYTHM_LEN[idx] : 4'd1;
  endfunction

endpackage

// ===== rtl/hrs_mul.sv =====
// Shared registered multiplier for the haptic rhythm sequencer.
// No package dependencies.
module hrs_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic               clk,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

// ===== rtl/haptic_rhythm_sequencer.sv =====
// Haptic rhythm sequencer top level: control sequencer, step datapath, config register.
// Depends on hrs_pkg, hrs_mul and haptic_rhythm_sequencer_assert.svh.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------------
//  request   | start in, busy out       | effect_code, pulse_ms
//  step      | strobe out (1 cycle)     | step_valid, drive_level, duration_ms,
//            |                          | total_ms, last_step
//  config    | cfg_valid in, cfg_ready  | cfg_data (ringtone_base)
//
// A request is taken on start && !busy. An unsupported code yields its single
// result the next cycle and the block stays ready. A rhythm walks its beats one
// at a time: a silence passes through fetch and emit, a pulse through fetch,
// two passes through the shared 16x16 multiplier for base*percent/100, and emit.
// The longest rhythm has nine beats, five of them pulses; busy drops with the
// last step strobe. Reset (rst, synchronous) restores ringtone_base to 6. The
// step receiver cannot stall; each strobe is a transfer.
`include "haptic_rhythm_sequencer_assert.svh"

module haptic_rhythm_sequencer #(
  parameter int NUM_RHYTHMS = 15,
  parameter int FULL_DRIVE  = 255
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  effect_code,
  input  logic [7:0]  pulse_ms,
  // step results
  output logic        strobe,
  output logic        step_valid,
  output logic [7:0]  drive_level,
  output logic [7:0]  duration_ms,
  output logic [11:0] total_ms,
  output logic        last_step,
  // config
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL_A,
    S_MUL_B,
    S_EMIT
  } state_t;

  state_t      state;
  logic [7:0]  ringtone_base;
  logic [7:0]  base_ms;
  logic [6:0]  beat_cursor;
  logic [3:0]  beats_left;
  logic [8:0]  beat;
  logic [8:0]  beat_rd;
  logic [7:0]  prev_pulse_pct;
  logic [7:0]  prev_pulse_len;
  logic [11:0] length_sum;

  // request decode
  logic [8:0]  code_diff;
  logic        code_ok;

  // shared multiplier
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] mul_p;

  // step datapath
  logic [9:0]  pulse_q;
  logic [8:0]  floor_ms;
  logic [7:0]  dur_next;
  logic [11:0] length_sum_next;

  assign cfg_ready = !busy;

  assign code_diff = {1'b0, effect_code} - {1'b0, ringtone_base};
  assign code_ok   = !code_diff[8] && (code_diff[7:0] < 8'(NUM_RHYTHMS));

  // beat ROM word at the cursor
  assign beat_rd = hrs_pkg::beat_word(beat_cursor);

  // first pass: base * percent; second pass: product * reciprocal of 100
  always_comb begin
    if (state == S_MUL_B) begin
      mul_a = mul_p[15:0];
      mul_b = hrs_pkg::RECIP_100;
    end else begin
      mul_a = {8'd0, base_ms};
      mul_b = {8'd0, beat[7:0]};
    end
  end

  hrs_mul #(
    .AW(16),
    .BW(16)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // duration of the current beat; mul_p holds the scaled quotient in S_EMIT
  always_comb begin
    pulse_q  = mul_p[hrs_pkg::RECIP_SHIFT +: 10];
    floor_ms = {prev_pulse_len, 1'b0};
    if (beat[8]) begin
      dur_next = (pulse_q > 10'(hrs_pkg::DUR_MAX)) ? hrs_pkg::DUR_MAX : pulse_q[7:0];
    end else if (prev_pulse_pct > hrs_pkg::PCT_UNITY) begin
      // silence after a strong pulse: at least twice that pulse, capped
      if (floor_ms >= 9'(hrs_pkg::DUR_MAX)) begin
        dur_next = hrs_pkg::DUR_MAX;
      end else begin
        dur_next = (beat[7:0] > floor_ms[7:0]) ? beat[7:0] : floor_ms[7:0];
      end
    end else begin
      dur_next = beat[7:0];
    end
    length_sum_next = length_sum + 12'(dur_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      busy           <= 1'b0;
      strobe         <= 1'b0;
      ringtone_base  <= 8'd6;
      prev_pulse_pct <= 8'd0;
      prev_pulse_len <= 8'd0;
      length_sum     <= 12'd0;
      beat_cursor    <= 7'd0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        ringtone_base <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            base_ms        <= pulse_ms;
            prev_pulse_pct <= 8'd0;
            prev_pulse_len <= 8'd0;
            length_sum     <= 12'd0;
            if (code_ok) begin
              beat_cursor <= hrs_pkg::rhythm_start(code_diff[3:0]);
              beats_left  <= hrs_pkg::rhythm_len(code_diff[3:0]);
              busy        <= 1'b1;
              state       <= S_FETCH;
            end else begin
              // unsupported effect: one empty, final, invalid step
              beat_cursor <= 7'd0;
              strobe      <= 1'b1;
              step_valid  <= 1'b0;
              drive_level <= 8'd0;
              duration_ms <= 8'd0;
              total_ms    <= 12'd0;
              last_step   <= 1'b1;
            end
          end
        end
        S_FETCH: begin
          beat  <= beat_rd;
          state <= beat_rd[8] ? S_MUL_A : S_EMIT;
        end
        S_MUL_A: begin
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe      <= 1'b1;
          step_valid  <= 1'b1;
          drive_level <= beat[8] ? 8'(FULL_DRIVE) : 8'd0;
          duration_ms <= dur_next;
          total_ms    <= length_sum_next;
          last_step   <= (beats_left == 4'd1);
          length_sum  <= length_sum_next;
          if (beat[8]) begin
            prev_pulse_pct <= beat[7:0];
            prev_pulse_len <= dur_next;
          end else begin
            prev_pulse_pct <= 8'd0;
          end
          if (beats_left == 4'd1) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            beats_left  <= beats_left - 4'd1;
            beat_cursor <= beat_cursor + 7'd1;
            state       <= S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HRS_ASSERT_IMPL(a_invalid_is_last, strobe && !step_valid, last_step, "invalid step not last")
  `HRS_ASSERT_IMPL(a_invalid_empty, strobe && !step_valid, (duration_ms == 8'd0) && (total_ms == 12'd0), "invalid step not empty")
  `HRS_ASSERT_IMPL(a_last_frees, strobe && step_valid && last_step, !busy, "busy after final step")
  `HRS_ASSERT_NEXT(a_emit_strobes, state == S_EMIT, strobe && step_valid, "emit without strobe")
  `HRS_ASSERT_IMPL(a_busy_state, busy, state != S_IDLE, "busy while idle")

endmodule
